/* sv/pulse_flash_output_timer_unit_defines.svh */
// Assertion macros used by the top-level RTL file of the output timer unit.
`ifndef PULSE_FLASH_OUTPUT_TIMER_UNIT_DEFINES_SVH
`define PULSE_FLASH_OUTPUT_TIMER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define PFOT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pfot assertion failed");
// Condition that must never be true outside reset.
`define PFOT_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("pfot forbidden condition seen");
`else
`define PFOT_ASSERT(lbl, prop)
`define PFOT_ASSERT_NEVER(lbl, cond)
`endif

`endif

/* sv/pfot_pkg.sv */
package pfot_pkg;

    // Number of output channels (1 to 8).
    localparam int CHANNELS = 8;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Operation codes of an input item.
    localparam logic [1:0] OP_COMMAND = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_RESTORE = 2'd2;

    // Action codes.
    localparam logic [1:0] ACT_ON    = 2'd0;
    localparam logic [1:0] ACT_OFF   = 2'd1;
    localparam logic [1:0] ACT_FLASH = 2'd2;

    // Persisted state codes.
    localparam logic [1:0] ST_ON    = 2'd0;
    localparam logic [1:0] ST_OFF   = 2'd1;
    localparam logic [1:0] ST_FLASH = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_INVERT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_INVERT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_INVERT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_EVENT_DISABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_TYPE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_DURATIONS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_PERIODS = 3'd6;

    // Configuration slice seen by one channel cell.
    typedef struct packed {
        logic       oinv;
        logic       tinv;
        logic       einv;
        logic       offdis;
        logic       otype;
        logic [7:0] dur;
        logic [7:0] per;
    } cell_cfg_t;

    // Control from the sequencer to each cell.
    typedef struct packed {
        logic       tick;
        logic       cmd;
        logic       restore;
        logic       shift;
        logic [1:0] action;
    } cell_ctrl_t;

    // Tick event carried along the cell chain.
    typedef struct packed {
        logic ev;
        logic on;
    } chain_t;

    // Outcome of an action command in the addressed cell.
    typedef struct packed {
        logic       ev;
        logic       on;
        logic       st;
        logic [1:0] sv;
    } cmd_res_t;

endpackage

/* sv/pfot_if.sv */
// Input item channel.
interface pfot_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [2:0] channel;
    logic [1:0] action;

    modport source (output valid, output operation, output channel, output action,
                    input ready);
    modport sink (input valid, input operation, input channel, input action,
                  output ready);
endinterface

// Result item channel.
interface pfot_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] pins;
    logic       event_valid;
    logic [2:0] event_channel;
    logic       event_polarity;
    logic       store_valid;
    logic [1:0] store_value;
    logic       last;

    modport source (output valid, output pins, output event_valid, output event_channel,
                    output event_polarity, output store_valid, output store_value,
                    output last, input ready);
    modport sink (input valid, input pins, input event_valid, input event_channel,
                  input event_polarity, input store_valid, input store_value,
                  input last, output ready);
endinterface

/* sv/pfot_cfg_regs.sv */
module pfot_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pfot_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfot_pkg::CFG_DATA_W-1:0]    cfg_data,
    output pfot_pkg::cell_cfg_t                cell_cfg [pfot_pkg::CHANNELS]
);

    logic [7:0]  oinv_reg;
    logic [7:0]  tinv_reg;
    logic [7:0]  einv_reg;
    logic [7:0]  offdis_reg;
    logic [7:0]  otype_reg;
    logic [63:0] dur_reg;
    logic [63:0] per_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oinv_reg   <= 8'h00;
            tinv_reg   <= 8'h00;
            einv_reg   <= 8'h00;
            offdis_reg <= 8'h00;
            otype_reg  <= 8'hFF;
            dur_reg    <= 64'd0;
            per_reg    <= 64'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pfot_pkg::REG_OUTPUT_INVERT:     oinv_reg   <= cfg_data[7:0];
                pfot_pkg::REG_TRIGGER_INVERT:    tinv_reg   <= cfg_data[7:0];
                pfot_pkg::REG_EVENT_INVERT:      einv_reg   <= cfg_data[7:0];
                pfot_pkg::REG_OFF_EVENT_DISABLE: offdis_reg <= cfg_data[7:0];
                pfot_pkg::REG_OUTPUT_TYPE:       otype_reg  <= cfg_data[7:0];
                pfot_pkg::REG_PULSE_DURATIONS:   dur_reg    <= cfg_data;
                pfot_pkg::REG_FLASH_PERIODS:     per_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Each cell sees only its own bit of every mask and its own byte of the timings.
    always_comb
    begin
        for (int c = 0; c < pfot_pkg::CHANNELS; c++)
        begin
            cell_cfg[c].oinv   = oinv_reg[c];
            cell_cfg[c].tinv   = tinv_reg[c];
            cell_cfg[c].einv   = einv_reg[c];
            cell_cfg[c].offdis = offdis_reg[c];
            cell_cfg[c].otype  = otype_reg[c];
            cell_cfg[c].dur    = dur_reg[8*c +: 8];
            cell_cfg[c].per    = per_reg[8*c +: 8];
        end
    end

endmodule

/* sv/pfot_cell.sv */
module pfot_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfot_pkg::cell_ctrl_t ctrl,
    input  pfot_pkg::cell_cfg_t  cfg,
    input  pfot_pkg::chain_t     chain_in,
    output pfot_pkg::chain_t     chain_out,
    output logic                 pin,
    output pfot_pkg::cmd_res_t   cmd_res
);

    logic       pin_reg, pin_next;
    logic [7:0] pc_reg, pc_next;
    logic [7:0] fc_reg, fc_next;
    logic       ev_reg, ev_next;
    logic       on_reg, on_next;

    logic       act;
    logic [7:0] f;
    logic       p;
    logic       t_ev;
    logic [7:0] pc_dec;

    // Outcome of an action command, from the state before the command.
    always_comb
    begin
        act = (ctrl.action == pfot_pkg::ACT_ON) ^ cfg.tinv;
        cmd_res = '0;
        if (ctrl.action == pfot_pkg::ACT_FLASH)
        begin
            cmd_res.ev = 1'b1;
            cmd_res.on = ~cfg.einv;
            cmd_res.st = 1'b1;
            cmd_res.sv = pfot_pkg::ST_FLASH;
        end
        else if (!(!act && cfg.dur != 8'd0))
        begin
            cmd_res.ev = cfg.otype & (act | ~cfg.offdis);
            cmd_res.on = cmd_res.ev & (act ^ cfg.einv);
            cmd_res.st = 1'b1;
            if (act && cfg.dur != 8'd0 && pc_reg == 8'd0)
                cmd_res.sv = pfot_pkg::ST_OFF;
            else
                cmd_res.sv = act ? pfot_pkg::ST_ON : pfot_pkg::ST_OFF;
        end
    end

    always_comb
    begin
        pin_next = pin_reg;
        pc_next  = pc_reg;
        fc_next  = fc_reg;
        ev_next  = ev_reg;
        on_next  = on_reg;
        f        = fc_reg;
        p        = pin_reg;
        t_ev     = 1'b0;
        pc_dec   = pc_reg - 8'd1;

        if (ctrl.tick)
        begin
            if (cfg.otype)
            begin
                // Flash half-period counter runs signed toward +1 or -1.
                if (f == 8'h01)
                begin
                    p = cfg.oinv;
                    f = 8'h00 - cfg.per;
                end
                if (f == 8'hFF)
                begin
                    p = ~cfg.oinv;
                    f = cfg.per;
                end
                if (f >= 8'h02 && f <= 8'h7F)
                    f = f - 8'd1;
                else if (f >= 8'h80 && f <= 8'hFE)
                    f = f + 8'd1;
                fc_next = f;

                if (pc_reg != 8'd0)
                begin
                    pc_next = pc_dec;
                    if (pc_dec == 8'd1)
                    begin
                        p    = cfg.oinv;
                        t_ev = ~cfg.offdis;
                    end
                end
                pin_next = p;
            end
            ev_next = t_ev;
            on_next = t_ev & cfg.einv;
        end
        else if (ctrl.shift)
        begin
            ev_next = chain_in.ev;
            on_next = chain_in.on;
        end

        if (ctrl.cmd)
        begin
            if (ctrl.action == pfot_pkg::ACT_FLASH)
            begin
                fc_next  = cfg.per;
                pc_next  = 8'd1;
                pin_next = ~cfg.oinv;
            end
            else
            begin
                fc_next = 8'd0;
                if (!act && cfg.dur != 8'd0)
                    pc_next = 8'd1;
                else
                begin
                    if (act && cfg.dur != 8'd0 && pc_reg == 8'd0)
                        pc_next = cfg.dur;
                    else
                        pc_next = 8'd1;
                    pin_next = act ^ cfg.oinv;
                end
            end
        end

        if (ctrl.restore)
        begin
            if (ctrl.action == pfot_pkg::ACT_FLASH)
            begin
                fc_next  = cfg.per;
                pin_next = 1'b1;
            end
            else
                pin_next = (ctrl.action == pfot_pkg::ACT_ON) ^ cfg.oinv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_reg <= 1'b0;
            pc_reg  <= 8'd0;
            fc_reg  <= 8'd0;
            ev_reg  <= 1'b0;
            on_reg  <= 1'b0;
        end
        else
        begin
            pin_reg <= pin_next;
            pc_reg  <= pc_next;
            fc_reg  <= fc_next;
            ev_reg  <= ev_next;
            on_reg  <= on_next;
        end
    end

    assign pin          = pin_reg;
    assign chain_out.ev = ev_reg;
    assign chain_out.on = on_reg;

endmodule

/* sv/pulse_flash_output_timer_unit.sv */
// Channel    Direction  Handshake          Payload
// item       in         valid/ready        operation, channel, action
// result     out        valid/ready        pins, event_*, store_*, last
// cfg        in         cfg_we (no ready)  cfg_index, cfg_data
//
// An item is taken only while no result is pending; it updates the channel
// cells in the cycle it is accepted, and its first result is offered in the
// next cycle. A command or restore gives one result. A tick gives one result per
// channel, shifted out of the cell chain one per cycle while the sink takes each
// result. A stalled result holds the chain and the input. Reset clears all state
// but the output type mask, which resets to all ones.

`include "pulse_flash_output_timer_unit_defines.svh"

module pulse_flash_output_timer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    pfot_item_if.sink                       item,
    pfot_result_if.source                   result,
    input  logic                            cfg_we,
    input  logic [pfot_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfot_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam logic [pfot_pkg::CH_IDX_W-1:0] LAST_IDX =
        pfot_pkg::CH_IDX_W'(pfot_pkg::CHANNELS - 1);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } state_t;

    state_t                          state_reg;
    logic                            tick_reg;
    logic [pfot_pkg::CH_IDX_W-1:0]   idx_reg;
    logic [2:0]                      chan_reg;
    pfot_pkg::cmd_res_t              res_reg;

    pfot_pkg::cell_cfg_t  cell_cfg  [pfot_pkg::CHANNELS];
    pfot_pkg::cell_ctrl_t cell_ctrl [pfot_pkg::CHANNELS];
    pfot_pkg::chain_t     chain     [pfot_pkg::CHANNELS+1];
    pfot_pkg::cmd_res_t   cell_res  [pfot_pkg::CHANNELS];
    logic [pfot_pkg::CHANNELS-1:0] cell_pin;

    logic               accept;
    logic               out_take;
    logic               emit_done;
    pfot_pkg::cmd_res_t sel_res;
    logic [7:0]         pins_vec;

    assign accept    = item.valid && item.ready;
    assign out_take  = result.valid && result.ready;
    assign emit_done = !tick_reg || (idx_reg == LAST_IDX);

    pfot_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cell_cfg  (cell_cfg)
    );

    // The last cell shifts in an empty event slot.
    assign chain[pfot_pkg::CHANNELS] = '0;

    // The command and restore go to the addressed cell only; a tick reaches all
    // cells, and the shift moves tick events one cell toward the output.
    always_comb
    begin
        for (int c = 0; c < pfot_pkg::CHANNELS; c++)
        begin
            cell_ctrl[c].tick    = accept && (item.operation == pfot_pkg::OP_TICK);
            cell_ctrl[c].cmd     = accept && (item.operation == pfot_pkg::OP_COMMAND) &&
                                   (item.channel == 3'(c));
            cell_ctrl[c].restore = accept && (item.operation == pfot_pkg::OP_RESTORE) &&
                                   (item.channel == 3'(c));
            cell_ctrl[c].shift   = out_take && tick_reg;
            cell_ctrl[c].action  = item.action;
        end
    end

    genvar g;
    generate
        for (g = 0; g < pfot_pkg::CHANNELS; g++)
        begin : g_cell
            pfot_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl[g]),
                .cfg       (cell_cfg[g]),
                .chain_in  (chain[g+1]),
                .chain_out (chain[g]),
                .pin       (cell_pin[g]),
                .cmd_res   (cell_res[g])
            );
        end
    endgenerate

    // Pick the command outcome of the addressed cell; an out-of-range channel,
    // a restore and an unused operation give an empty result.
    always_comb
    begin
        sel_res = '0;
        if (item.operation == pfot_pkg::OP_COMMAND)
        begin
            for (int c = 0; c < pfot_pkg::CHANNELS; c++)
            begin
                if (item.channel == 3'(c))
                    sel_res = sel_res | cell_res[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tick_reg  <= 1'b0;
            idx_reg   <= '0;
            chan_reg  <= 3'd0;
            res_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EMIT;
                        tick_reg  <= (item.operation == pfot_pkg::OP_TICK);
                        idx_reg   <= '0;
                        chan_reg  <= item.channel;
                        res_reg   <= sel_res;
                    end
                end
                S_EMIT:
                begin
                    if (out_take)
                    begin
                        if (emit_done)
                            state_reg <= S_IDLE;
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Pins beyond the configured channel count stay low.
    always_comb
    begin
        pins_vec = 8'h00;
        for (int c = 0; c < pfot_pkg::CHANNELS; c++)
            pins_vec[c] = cell_pin[c];
    end

    assign item.ready = (state_reg == S_IDLE);

    assign result.valid          = (state_reg == S_EMIT);
    assign result.pins           = pins_vec;
    assign result.event_valid    = tick_reg ? chain[0].ev : res_reg.ev;
    assign result.event_polarity = tick_reg ? chain[0].on : res_reg.on;
    assign result.event_channel  = tick_reg ? 3'(idx_reg) : chan_reg;
    assign result.store_valid    = tick_reg ? 1'b0 : res_reg.st;
    assign result.store_value    = tick_reg ? pfot_pkg::ST_ON : res_reg.sv;
    assign result.last           = emit_done;

    // No item is taken while a result is still offered.
    `PFOT_ASSERT_NEVER(a_no_overlap, item.ready && result.valid)
    // Every accepted item offers its first result in the next cycle.
    `PFOT_ASSERT(a_result_follows, accept |=> result.valid)
    // The final result of an item returns the block to accepting items.
    `PFOT_ASSERT(a_last_frees, (out_take && result.last) |=> item.ready)
    // Pin levels are those after the whole item, so they stay put across its results.
    `PFOT_ASSERT(a_pins_hold, (out_take && !result.last) |=> (result.valid && $stable(result.pins)))

endmodule
